>>> rtl/core/modbus_read_response_checker_top_assert.svh
// Assertion macros used by the RTL of the Modbus reply checker.
// Every property is sampled on the rising edge of clk and is disabled while arst_n is low.
`ifndef MODBUS_READ_RESPONSE_CHECKER_TOP_ASSERT_SVH
`define MODBUS_READ_RESPONSE_CHECKER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define MRRC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mrrc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MRRC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mrrc assertion failed");

`else

`define MRRC_ASSERT_IMP(lbl, ante, cons)
`define MRRC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/mrrc_pkg.sv
package mrrc_pkg;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [2:0]  channel;
		logic [13:0] voltage_mv;
		logic        reading_valid;
		logic        last;
	} result_t;

	// Control from the sequencer to the CRC unit.
	typedef struct packed {
		logic       clear;
		logic       start;
		logic [7:0] data;
	} crc_ctl_t;

	// Request to the calibration unit.
	typedef struct packed {
		logic        start;
		logic        raw_ok;
		logic [13:0] raw;
		logic [15:0] gain;
		logic [15:0] offset;
	} cal_req_t;

	localparam logic [1:0] FN_START   = 2'd0;
	localparam logic [1:0] FN_BYTE    = 2'd1;
	localparam logic [1:0] FN_TIMEOUT = 2'd2;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_NONE       = 4'd1;
	localparam logic [3:0] ST_SHORT      = 4'd2;
	localparam logic [3:0] ST_ADDR       = 4'd3;
	localparam logic [3:0] ST_EXCEPTION  = 4'd4;
	localparam logic [3:0] ST_FUNC       = 4'd5;
	localparam logic [3:0] ST_COUNT      = 4'd6;
	localparam logic [3:0] ST_INCOMPLETE = 4'd7;
	localparam logic [3:0] ST_CRC        = 4'd8;

	localparam logic [4:0]  FRAME_LEN     = 5'd21;
	localparam logic [4:0]  CRC_SPAN      = 5'd19;
	localparam logic [4:0]  MIN_LEN       = 5'd5;
	localparam logic [4:0]  IDX_ADDR      = 5'd0;
	localparam logic [4:0]  IDX_FUNC      = 5'd1;
	localparam logic [4:0]  IDX_COUNT     = 5'd2;
	localparam logic [4:0]  IDX_CRC_LO    = 5'd19;
	localparam logic [4:0]  IDX_CRC_HI    = 5'd20;
	localparam logic [4:0]  IDX_REG0_HI   = 5'd3;
	localparam logic [7:0]  SLAVE_ADDRESS = 8'd1;
	localparam logic [7:0]  FC_READ_HOLD  = 8'h03;
	localparam int          EXC_BIT       = 7;
	localparam logic [7:0]  REG_DATA_LEN  = 8'd16;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [13:0] FULL_SCALE_MV = 14'd10000;
	localparam logic [31:0] CAL_RESET     = 32'h4000_0000;

endpackage

>>> rtl/core/mrrc_crc.sv
module mrrc_crc import mrrc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  crc_ctl_t ctl,
	output logic     busy,
	output logic [15:0] crc
);

	logic [15:0] crc_q;
	logic [2:0]  bit_q;
	logic        busy_q;

	// One shift of the reflected CRC-16 per cycle, eight per byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			bit_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctl.clear) begin
			crc_q  <= CRC_INIT;
			bit_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			crc_q  <= crc_q ^ {8'h00, ctl.data};
			bit_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
			bit_q <= bit_q + 3'd1;
			if (bit_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign crc  = crc_q;

endmodule

>>> rtl/core/mrrc_cal.sv
module mrrc_cal import mrrc_pkg::*; (
	input  logic        clk,
	input  cal_req_t    req,
	output logic [13:0] mv,
	output logic        ok
);

	logic [29:0] prod_s1;
	logic [15:0] off_s1;
	logic        ok_s1;
	logic [13:0] mv_s2;
	logic        ok_s2;
	logic [15:0] scaled;
	logic signed [17:0] sum;

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_s1 <= {16'h0000, req.raw} * {14'h0000, req.gain};
			off_s1  <= req.offset;
			ok_s1   <= req.raw_ok;
		end
	end

	always_comb begin
		scaled = prod_s1[29:14];
		sum    = $signed({2'b00, scaled}) + $signed({{2{off_s1[15]}}, off_s1});
	end

	// Clamp to 0..full scale; an out-of-range raw value reads as zero.
	always_ff @(posedge clk) begin
		ok_s2 <= ok_s1;
		if (!ok_s1 || sum[17]) begin
			mv_s2 <= '0;
		end else if (sum[16:0] > {3'b000, FULL_SCALE_MV}) begin
			mv_s2 <= FULL_SCALE_MV;
		end else begin
			mv_s2 <= sum[13:0];
		end
	end

	assign mv = mv_s2;
	assign ok = ok_s2;

endmodule

>>> rtl/core/modbus_read_response_checker_top.sv
// Checks Modbus RTU read-holding-registers replies fed in one byte per transfer. A start
// transfer clears the frame; for each of the first 19 bytes the bit-serial CRC-16 unit shifts
// the byte in, and item_ready stays low meanwhile. The reply is checked on its 21st byte or
// on a timeout transfer. An error yields one status result; a good frame yields CHANNELS
// results, one at a time, each made by two reads of the frame memory and the two-stage
// multiply and clamp of the calibration unit, and held back while result_ready is low.
// Bytes and timeouts after the check are dropped until the next start.
module modbus_read_response_checker_top import mrrc_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	`include "modbus_read_response_checker_top_assert.svh"

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_RDHI  = 3'd2;
	localparam logic [2:0] S_RDLO  = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_CAL   = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0]  state_q;
	logic [4:0]  cnt_q;
	logic        finished_q;
	logic [2:0]  ch_q;
	logic [31:0] cal_q [CHANNELS];
	logic [7:0]  frame_mem [21];
	logic [7:0]  rd_q;
	logic [4:0]  rd_addr;
	logic [7:0]  raw_hi_q;
	logic [7:0]  hdr_addr_q;
	logic [7:0]  hdr_func_q;
	logic [7:0]  hdr_count_q;
	logic [7:0]  crc_lo_q;
	logic [7:0]  crc_hi_q;
	logic        accept;
	logic        byte_take;
	logic        out_free;
	logic        load;
	logic        last_ch;
	logic [3:0]  status;
	logic [15:0] raw;
	logic [31:0] cal_word;
	crc_ctl_t    crc_ctl;
	cal_req_t    cal_req;
	logic        crc_busy;
	logic [15:0] crc;
	logic [13:0] cal_mv;
	logic        cal_ok;
	logic        result_valid_q;
	result_t     result_q;

	assign item_ready = (state_q == S_IDLE) && !crc_busy;
	assign accept     = item_valid && item_ready;
	assign byte_take  = accept && (item.func == FN_BYTE) && !finished_q && (cnt_q < FRAME_LEN);
	assign out_free   = !result_valid_q || result_ready;
	assign last_ch    = (ch_q == 3'(CHANNELS - 1));

	always_comb begin
		crc_ctl.clear = accept && (item.func == FN_START);
		crc_ctl.start = byte_take && (cnt_q < CRC_SPAN);
		crc_ctl.data  = item.rx_byte;
	end

	mrrc_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.busy   (crc_busy),
		.crc    (crc)
	);

	always_comb begin
		if (cnt_q == 5'd0) begin
			status = ST_NONE;
		end else if (cnt_q < MIN_LEN) begin
			status = ST_SHORT;
		end else if (hdr_addr_q != SLAVE_ADDRESS) begin
			status = ST_ADDR;
		end else if (hdr_func_q[EXC_BIT]) begin
			status = ST_EXCEPTION;
		end else if (hdr_func_q != FC_READ_HOLD) begin
			status = ST_FUNC;
		end else if (hdr_count_q != REG_DATA_LEN) begin
			status = ST_COUNT;
		end else if (cnt_q < FRAME_LEN) begin
			status = ST_INCOMPLETE;
		end else if ({crc_hi_q, crc_lo_q} != crc) begin
			status = ST_CRC;
		end else begin
			status = ST_OK;
		end
	end

	// Calibration words, one per channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cal_q[i] <= CAL_RESET;
			end
		end else if (cfg_we && ({1'b0, cfg_index} < 4'(CHANNELS))) begin
			cal_q[cfg_index[CH_W-1:0]] <= cfg_wdata;
		end
	end

	// Frame memory and the header fields that the check needs at fixed places.
	always_ff @(posedge clk) begin
		if (byte_take) begin
			frame_mem[cnt_q] <= item.rx_byte;
			if (cnt_q == IDX_ADDR)   hdr_addr_q  <= item.rx_byte;
			if (cnt_q == IDX_FUNC)   hdr_func_q  <= item.rx_byte;
			if (cnt_q == IDX_COUNT)  hdr_count_q <= item.rx_byte;
			if (cnt_q == IDX_CRC_LO) crc_lo_q    <= item.rx_byte;
			if (cnt_q == IDX_CRC_HI) crc_hi_q    <= item.rx_byte;
		end
		rd_q <= frame_mem[rd_addr];
		if (state_q == S_RDLO) begin
			raw_hi_q <= rd_q;
		end
	end

	always_comb begin
		rd_addr = IDX_REG0_HI + {1'b0, ch_q, 1'b0};
		if (state_q == S_RDLO) begin
			rd_addr = IDX_REG0_HI + {1'b0, ch_q, 1'b0} + 5'd1;
		end
	end

	always_comb begin
		raw             = {raw_hi_q, rd_q};
		cal_word        = cal_q[ch_q[CH_W-1:0]];
		cal_req.start   = (state_q == S_MUL);
		cal_req.raw_ok  = (raw <= {2'b00, FULL_SCALE_MV});
		cal_req.raw     = raw[13:0];
		cal_req.gain    = cal_word[31:16];
		cal_req.offset  = cal_word[15:0];
	end

	mrrc_cal u_cal (
		.clk (clk),
		.req (cal_req),
		.mv  (cal_mv),
		.ok  (cal_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			finished_q <= 1'b0;
			ch_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.func == FN_START) begin
							cnt_q      <= '0;
							finished_q <= 1'b0;
						end else if (byte_take) begin
							cnt_q <= cnt_q + 5'd1;
							if (cnt_q == FRAME_LEN - 5'd1) begin
								finished_q <= 1'b1;
								state_q    <= S_CHECK;
							end
						end else if (item.func == FN_TIMEOUT && !finished_q) begin
							finished_q <= 1'b1;
							state_q    <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (status == ST_OK) begin
						ch_q    <= '0;
						state_q <= S_RDHI;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RDHI: state_q <= S_RDLO;
				S_RDLO: state_q <= S_MUL;
				S_MUL:  state_q <= S_CAL;
				S_CAL:  state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						if (last_ch) begin
							state_q <= S_IDLE;
						end else begin
							ch_q    <= ch_q + 3'd1;
							state_q <= S_RDHI;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign load = out_free && (((state_q == S_CHECK) && (status != ST_OK)) ||
		(state_q == S_EMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (state_q == S_CHECK) begin
				result_q.status        <= status;
				result_q.channel       <= '0;
				result_q.voltage_mv    <= '0;
				result_q.reading_valid <= 1'b0;
				result_q.last          <= 1'b1;
			end else begin
				result_q.status        <= ST_OK;
				result_q.channel       <= ch_q;
				result_q.voltage_mv    <= cal_mv;
				result_q.reading_valid <= cal_ok;
				result_q.last          <= last_ch;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`MRRC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= FRAME_LEN)
	`MRRC_ASSERT_IMP(a_busy_finished, state_q != S_IDLE, finished_q)
	`MRRC_ASSERT_IMP(a_error_single, result_valid_q && (result_q.status != ST_OK),
		result_q.last && (result_q.channel == 3'd0) && !result_q.reading_valid)
	`MRRC_ASSERT_IMP(a_channel_range, result_valid_q && (result_q.status == ST_OK),
		{1'b0, result_q.channel} < 4'(CHANNELS))
	`MRRC_ASSERT_NXT(a_crc_idle, crc_ctl.start, crc_busy && (state_q == S_IDLE))

endmodule
